[rtl/rtcb_pkg.sv]
// ----------------------------------------------------------------------------
// rtcb_pkg
// Shared codes, field positions and BCD helpers for the three-wire RTC burst
// master and its port checker.
// ----------------------------------------------------------------------------
package rtcb_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_START_WR = 2'd1;
    localparam logic [1:0] OP_START_RD = 2'd2;

    // Transaction modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Burst write sequence steps
    localparam logic [3:0] WSTEP_WP_ADDR    = 4'd0;
    localparam logic [3:0] WSTEP_WP_DATA    = 4'd1;
    localparam logic [3:0] WSTEP_CE_PULSE   = 4'd2;
    localparam logic [3:0] WSTEP_BURST_CMD  = 4'd3;
    localparam logic [3:0] WSTEP_TIME_FIRST = 4'd4;
    localparam logic [3:0] WSTEP_CTRL       = 4'd11;

    // Burst read sequence steps
    localparam logic [3:0] RSTEP_CMD  = 4'd0;
    localparam logic [3:0] RSTEP_DATA = 4'd1;

    // Command and data bytes
    localparam logic [7:0] CMD_WP_ADDR   = 8'h8E;
    localparam logic [7:0] CMD_WP_CLEAR  = 8'h00;
    localparam logic [7:0] CMD_BURST_WR  = 8'hBE;
    localparam logic [7:0] CMD_BURST_RD  = 8'hBF;
    localparam logic [7:0] CTRL_RESET    = 8'h80;

    // Number of time bytes presented on a burst read
    localparam logic [3:0] TIME_BYTES = 4'd7;

    // Output tdata bit positions
    localparam int OB_CLK    = 0;
    localparam int OB_IO     = 1;
    localparam int OB_OE     = 2;
    localparam int OB_CE     = 3;
    localparam int OB_BUSY   = 4;
    localparam int OB_DONE   = 5;
    localparam int OB_IDX_LO = 6;
    localparam int OB_VAL_LO = 9;

    typedef logic [7:0] t_byte;

    // Decimal to BCD; the divide by ten is a multiply by 205/2048
    function automatic t_byte to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        r    = v - 7'(q) * 7'd10;
        return {q, r[3:0]};
    endfunction

    // BCD to decimal with the tens digit masked to three bits
    function automatic logic [6:0] from_bcd(input t_byte b);
        return 7'(b[6:4]) * 7'd10 + 7'(b[3:0]);
    endfunction

endpackage

[rtl/rtc_three_wire_burst_master_core.sv]
// ----------------------------------------------------------------------------
// rtc_three_wire_burst_master_core
// Tick-driven burst master for a three-wire serial real-time-clock link.
// ----------------------------------------------------------------------------
// Every input transfer is one half-bit tick of the serial link and produces
// exactly one output transfer, registered and offered in the next cycle, carrying the pin levels,
// status flags and any decoded time byte. A new transfer is taken in every
// cycle; the single output register sets the figure, so while it holds an
// untaken result the input is ready only in a cycle in which the output is
// taken. A start write sends 0x8E, 0x00, pulses chip enable low for one tick,
// then sends 0xBE, seven BCD time bytes and the control byte; a start read
// sends 0xBF and returns seven decoded time bytes. Starts while busy are
// ignored. Bits go least significant first, clock low then clock high.
// ----------------------------------------------------------------------------
module rtc_three_wire_burst_master_core
    import rtcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: set_seconds(6), set_minutes(6), set_hour(5), set_date(5),
    // set_month(4), set_weekday(3), set_year(7), io_sample(1), zero pad(3)
    input  logic [39:0] s_axis_tdata,
    // tuser: opcode(2)
    input  logic [1:0]  s_axis_tuser,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: serial_clock, io_level, io_enable, chip_enable,
    // busy_res, done_res, read_index(3), read_value(7)
    output logic [15:0] m_axis_tdata,
    // tuser: read_valid(1)
    output logic [0:0]  m_axis_tuser,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Input field split
    logic [5:0] set_seconds, set_minutes;
    logic [4:0] set_hour, set_date;
    logic [3:0] set_month;
    logic [2:0] set_weekday;
    logic [6:0] set_year;
    logic       io_sample;
    logic [1:0] opcode;

    assign set_seconds = s_axis_tdata[5:0];
    assign set_minutes = s_axis_tdata[11:6];
    assign set_hour    = s_axis_tdata[16:12];
    assign set_date    = s_axis_tdata[21:17];
    assign set_month   = s_axis_tdata[25:22];
    assign set_weekday = s_axis_tdata[28:26];
    assign set_year    = s_axis_tdata[35:29];
    assign io_sample   = s_axis_tdata[36];
    assign opcode      = s_axis_tuser;

    // Sequencer state
    logic [1:0] r_mode, n_mode;
    logic [3:0] r_step, n_step;
    logic [3:0] r_phase, n_phase;
    logic [3:0] r_count, n_count;
    t_byte      r_shift, n_shift;
    t_byte      r_hold [7];
    t_byte      n_hold [7];
    logic       r_ce, n_ce;
    logic       r_clk, n_clk;
    logic       r_io, n_io;
    logic       r_oe, n_oe;
    t_byte      r_ctrl;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        r_out_user;

    logic       accept;
    logic       done, rvalid;
    logic [2:0] ridx;
    logic [6:0] rval;
    logic [2:0] bit_sel;
    logic [3:0] hold_off;
    t_byte      send_byte;
    logic       phase_last;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign bit_sel       = r_phase[3:1];
    assign phase_last    = (r_phase == 4'hF);
    assign hold_off      = r_step - WSTEP_TIME_FIRST;

    // Byte sent in the current write or read command step
    always_comb begin
        if (r_mode == MODE_READ) begin
            send_byte = CMD_BURST_RD;
        end else if (r_step == WSTEP_WP_ADDR) begin
            send_byte = CMD_WP_ADDR;
        end else if (r_step == WSTEP_WP_DATA) begin
            send_byte = CMD_WP_CLEAR;
        end else if (r_step == WSTEP_BURST_CMD) begin
            send_byte = CMD_BURST_WR;
        end else if (r_step == WSTEP_CTRL) begin
            send_byte = r_ctrl;
        end else begin
            send_byte = r_hold[hold_off[2:0]];
        end
    end

    // Next state and result for one tick
    always_comb begin
        n_mode  = r_mode;
        n_step  = r_step;
        n_phase = r_phase;
        n_count = r_count;
        n_shift = r_shift;
        n_hold  = r_hold;
        n_ce    = r_ce;
        n_clk   = r_clk;
        n_io    = r_io;
        n_oe    = r_oe;
        done    = 1'b0;
        rvalid  = 1'b0;
        ridx    = '0;
        rval    = '0;

        if (r_mode == MODE_IDLE) begin
            if (opcode == OP_START_WR || opcode == OP_START_RD) begin
                if (opcode == OP_START_WR) begin
                    n_hold[0] = to_bcd({1'b0, set_seconds});
                    n_hold[1] = to_bcd({1'b0, set_minutes});
                    n_hold[2] = to_bcd({2'b0, set_hour});
                    n_hold[3] = to_bcd({2'b0, set_date});
                    n_hold[4] = to_bcd({3'b0, set_month});
                    n_hold[5] = to_bcd({4'b0, set_weekday});
                    n_hold[6] = to_bcd(set_year);
                    n_mode    = MODE_WRITE;
                end else begin
                    n_mode    = MODE_READ;
                end
                n_step  = '0;
                n_phase = '0;
                n_count = '0;
                n_ce    = 1'b1;
                n_clk   = 1'b0;
                n_io    = 1'b0;
                n_oe    = 1'b1;
            end
        end else if (opcode == OP_TICK) begin
            if (r_mode == MODE_WRITE && r_step == WSTEP_CE_PULSE) begin
                // Chip enable drops for one tick between the two commands
                n_ce   = 1'b0;
                n_clk  = 1'b0;
                n_io   = 1'b0;
                n_oe   = 1'b1;
                n_step = WSTEP_BURST_CMD;
            end else if ((r_mode == MODE_WRITE && r_step <= WSTEP_CTRL) ||
                         (r_mode == MODE_READ && r_step == RSTEP_CMD)) begin
                // Shift one half-bit of the outgoing byte
                n_clk   = r_phase[0];
                n_io    = send_byte[bit_sel];
                n_oe    = 1'b1;
                n_ce    = 1'b1;
                n_phase = r_phase + 4'd1;
                if (phase_last) begin
                    n_step = r_step + 4'd1;
                end
            end else if (r_mode == MODE_READ && r_step == RSTEP_DATA) begin
                // Sample on the clock-low tick, present on the last clock-high
                n_shift = (r_phase == 4'd0) ? '0 : r_shift;
                if (!r_phase[0] && io_sample) begin
                    n_shift[bit_sel] = 1'b1;
                end
                n_clk   = r_phase[0];
                n_io    = 1'b0;
                n_oe    = 1'b0;
                n_ce    = 1'b1;
                n_phase = r_phase + 4'd1;
                if (phase_last) begin
                    if (r_count < TIME_BYTES) begin
                        rvalid = 1'b1;
                        ridx   = r_count[2:0];
                        rval   = from_bcd(n_shift);
                    end
                    n_count = r_count + 4'd1;
                    if (r_count >= TIME_BYTES) begin
                        n_step = r_step + 4'd1;
                    end
                end
            end else begin
                // Closing tick
                n_mode  = MODE_IDLE;
                n_step  = '0;
                n_phase = '0;
                n_count = '0;
                n_ce    = 1'b0;
                n_clk   = 1'b0;
                n_io    = 1'b0;
                n_oe    = 1'b0;
                done    = 1'b1;
            end
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_step  <= '0;
            r_phase <= '0;
            r_count <= '0;
            r_shift <= '0;
            r_ce    <= 1'b0;
            r_clk   <= 1'b0;
            r_io    <= 1'b0;
            r_oe    <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            r_ce    <= n_ce;
            r_clk   <= n_clk;
            r_io    <= n_io;
            r_oe    <= n_oe;
        end
    end

    // Time byte store, written on a start write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= n_hold;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {rval, ridx, done, (n_mode != MODE_IDLE),
                           n_ce, n_oe, n_io, n_clk};
            r_out_user <= rvalid;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= CTRL_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_ctrl <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_ctrl};

endmodule

[rtl/rtcb_checker.sv]
// ----------------------------------------------------------------------------
// rtcb_checker
// Port-level checks for the three-wire RTC burst master, bound to the top.
// ----------------------------------------------------------------------------
module rtcb_checker
    import rtcb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output result changed while stalled");

    // Once idle, the clock, enable and chip enable pins are parked low
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !m_axis_tdata[OB_BUSY] |->
            !m_axis_tdata[OB_CLK] && !m_axis_tdata[OB_OE] && !m_axis_tdata[OB_CE])
        else $error("pins active while idle");

    // A decoded byte arrives on a clock-high tick of a busy read
    a_read_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && m_axis_tuser[0] |->
            m_axis_tdata[OB_BUSY] && m_axis_tdata[OB_CLK] && !m_axis_tdata[OB_OE])
        else $error("read byte outside a read clock-high tick");

    // Chip enable only drops while the master drives the data pin or at the end
    a_ce_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && m_axis_tdata[OB_BUSY] && !m_axis_tdata[OB_OE] |->
            m_axis_tdata[OB_CE])
        else $error("chip enable low during a read");

    // Done marks the end of a transaction
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && m_axis_tdata[OB_DONE] |-> !m_axis_tdata[OB_BUSY] &&
            !m_axis_tuser[0])
        else $error("done reported while still busy");

endmodule

bind rtc_three_wire_burst_master_core rtcb_checker u_rtcb_checker (.*);

[tb/rtc_three_wire_burst_master_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_three_wire_burst_master_core_checker
// Watches the tick stream, the pin stream and the configuration port of the
// three-wire RTC burst master. It keeps its own copy of the sequencer state,
// works out the pin levels and decoded time byte due for every accepted tick,
// and compares each output transfer field by field with the oldest one due.
// ----------------------------------------------------------------------------
module rtc_three_wire_burst_master_core_checker
    import rtcb_pkg::*;
#(
    parameter logic [2:0] CTRL_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fails,
    output int          o_pending
);

    // Seven time bytes plus the trailing byte that is thrown away
    localparam logic [3:0] READ_BYTES  = 4'd8;
    localparam logic [3:0] RSTEP_CLOSE = 4'd2;

    // Input tdata, highest field first
    typedef struct packed {
        logic [2:0] pad;
        logic       io_sample;
        logic [6:0] year;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_time_word;

    // Output tdata, highest field first
    typedef struct packed {
        logic [6:0] value;
        logic [2:0] index;
        logic       done;
        logic       busy;
        logic       ce;
        logic       oe;
        logic       io;
        logic       sclk;
    } t_pin_word;

    typedef struct packed {
        logic      valid;
        t_pin_word pins;
    } t_rtc_result;

    t_rtc_result pins_due_q[$];

    // Sequencer state as the block should hold it
    logic [1:0] mode;
    logic [3:0] step_no;
    logic [3:0] half_tick;
    logic [3:0] nbytes;
    logic [7:0] rx_byte;
    logic [7:0] time_bcd [0:6];
    logic [7:0] ctrl_byte;
    logic       ce_lvl;
    logic       sclk_lvl;
    logic       io_lvl;
    logic       oe_lvl;

    function automatic logic [7:0] bcd_encode(input logic [6:0] v);
        int unsigned tens;
        int unsigned units;
        tens  = v / 10;
        units = v % 10;
        return 8'((tens << 4) | units);
    endfunction

    // The tens digit keeps only three bits, so bad digits decode up to 85
    function automatic logic [6:0] bcd_decode(input logic [7:0] b);
        return 7'(int'(b[6:4]) * 10 + int'(b[3:0]));
    endfunction

    function automatic int field_differs(input string name, input logic [7:0] want_v,
                                         input logic [7:0] got_v);
        if (got_v === want_v)
            return 0;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, name, want_v, got_v);
        return 1;
    endfunction

    task automatic close_burst();
        mode      = MODE_IDLE;
        step_no   = '0;
        half_tick = '0;
        nbytes    = '0;
        ce_lvl    = 1'b0;
        sclk_lvl  = 1'b0;
        io_lvl    = 1'b0;
        oe_lvl    = 1'b0;
    endtask

    // One half-bit of a byte sent LSB first: clock low, then clock high
    task automatic shift_out(input logic [7:0] tx, output logic byte_end);
        sclk_lvl  = half_tick[0];
        io_lvl    = tx[half_tick[3:1]];
        oe_lvl    = 1'b1;
        ce_lvl    = 1'b1;
        half_tick = half_tick + 4'd1;
        byte_end  = (half_tick == 4'd0);
    endtask

    // One half-bit of a received byte; the pin is sampled on the clock-low tick
    task automatic shift_in(input logic io_bit, output logic byte_end);
        if (half_tick == 4'd0)
            rx_byte = '0;
        sclk_lvl = half_tick[0];
        io_lvl   = 1'b0;
        oe_lvl   = 1'b0;
        ce_lvl   = 1'b1;
        if (!half_tick[0] && io_bit)
            rx_byte[half_tick[3:1]] = 1'b1;
        half_tick = half_tick + 4'd1;
        byte_end  = (half_tick == 4'd0);
    endtask

    // Advances the sequencer by one tick and returns the transfer it must emit
    task automatic advance_rtc(input logic [1:0] op, input t_time_word w,
                               output t_rtc_result r);
        logic       byte_end;
        logic [7:0] tx;
        logic [3:0] slot;
        r = '0;
        if (mode == MODE_IDLE) begin
            if (op == OP_START_WR || op == OP_START_RD) begin
                if (op == OP_START_WR) begin
                    time_bcd[0] = bcd_encode(7'(w.seconds));
                    time_bcd[1] = bcd_encode(7'(w.minutes));
                    time_bcd[2] = bcd_encode(7'(w.hour));
                    time_bcd[3] = bcd_encode(7'(w.date));
                    time_bcd[4] = bcd_encode(7'(w.month));
                    time_bcd[5] = bcd_encode(7'(w.weekday));
                    time_bcd[6] = bcd_encode(w.year);
                end
                mode      = (op == OP_START_WR) ? MODE_WRITE : MODE_READ;
                step_no   = '0;
                half_tick = '0;
                nbytes    = '0;
                ce_lvl    = 1'b1;
                sclk_lvl  = 1'b0;
                io_lvl    = 1'b0;
                oe_lvl    = 1'b1;
            end
        end else if (op == OP_TICK) begin
            if (mode == MODE_WRITE) begin
                if (step_no == WSTEP_CE_PULSE) begin
                    // Chip enable drops for a single tick between the two commands
                    ce_lvl   = 1'b0;
                    sclk_lvl = 1'b0;
                    io_lvl   = 1'b0;
                    oe_lvl   = 1'b1;
                    step_no  = WSTEP_BURST_CMD;
                end else if (step_no <= WSTEP_CTRL) begin
                    slot = step_no - WSTEP_TIME_FIRST;
                    if (step_no == WSTEP_WP_ADDR)
                        tx = CMD_WP_ADDR;
                    else if (step_no == WSTEP_WP_DATA)
                        tx = CMD_WP_CLEAR;
                    else if (step_no == WSTEP_BURST_CMD)
                        tx = CMD_BURST_WR;
                    else if (step_no == WSTEP_CTRL)
                        tx = ctrl_byte;
                    else
                        tx = time_bcd[slot[2:0]];
                    shift_out(tx, byte_end);
                    if (byte_end)
                        step_no = step_no + 4'd1;
                end else begin
                    close_burst();
                    r.pins.done = 1'b1;
                end
            end else begin
                if (step_no == RSTEP_CMD) begin
                    shift_out(CMD_BURST_RD, byte_end);
                    if (byte_end)
                        step_no = RSTEP_DATA;
                end else if (step_no == RSTEP_DATA) begin
                    shift_in(w.io_sample, byte_end);
                    if (byte_end) begin
                        if (nbytes < TIME_BYTES) begin
                            r.valid      = 1'b1;
                            r.pins.index = nbytes[2:0];
                            r.pins.value = bcd_decode(rx_byte);
                        end
                        nbytes = nbytes + 4'd1;
                        if (nbytes >= READ_BYTES)
                            step_no = RSTEP_CLOSE;
                    end
                end else begin
                    close_burst();
                    r.pins.done = 1'b1;
                end
            end
        end
        r.pins.sclk = sclk_lvl;
        r.pins.io   = io_lvl;
        r.pins.oe   = oe_lvl;
        r.pins.ce   = ce_lvl;
        r.pins.busy = (mode != MODE_IDLE);
    endtask

    // Register access, output compare and prediction, all on the rising edge
    always @(posedge i_clk) begin
        t_rtc_result want;
        t_rtc_result got;
        int          bad;
        if (!i_rst_n) begin
            close_burst();
            rx_byte   = '0;
            ctrl_byte = CTRL_RESET;
            for (int k = 0; k < 7; k++)
                time_bcd[k] = '0;
            pins_due_q.delete();
            o_fails   <= 0;
            o_pending <= 0;
        end else begin
            bad = 0;
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == CTRL_ADDR)
                        ctrl_byte = i_pwdata[7:0];
                end else if (i_paddr == CTRL_ADDR && i_prdata !== {24'h0, ctrl_byte}) begin
                    $display("%0t ns: register read mismatch, expected %0h, actual %0h",
                             $time, {24'h0, ctrl_byte}, i_prdata);
                    bad++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser[0], i_m_tdata};
                if (pins_due_q.size() == 0) begin
                    $display("%0t ns: output transfer with none due, expected none, actual %0h",
                             $time, got);
                    bad++;
                end else begin
                    want = pins_due_q.pop_front();
                    bad += field_differs("read_valid", 8'(want.valid), 8'(got.valid));
                    bad += field_differs("serial_clock", 8'(want.pins.sclk),
                                         8'(got.pins.sclk));
                    bad += field_differs("io_level", 8'(want.pins.io), 8'(got.pins.io));
                    bad += field_differs("io_enable", 8'(want.pins.oe), 8'(got.pins.oe));
                    bad += field_differs("chip_enable", 8'(want.pins.ce), 8'(got.pins.ce));
                    bad += field_differs("busy_res", 8'(want.pins.busy), 8'(got.pins.busy));
                    bad += field_differs("done_res", 8'(want.pins.done), 8'(got.pins.done));
                    bad += field_differs("read_index", 8'(want.pins.index),
                                         8'(got.pins.index));
                    bad += field_differs("read_value", 8'(want.pins.value),
                                         8'(got.pins.value));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_rtc(i_s_tuser, i_s_tdata, want);
                pins_due_q.push_back(want);
            end
            o_fails   <= o_fails + bad;
            o_pending <= pins_due_q.size();
        end
    end

endmodule

[tb/rtc_three_wire_burst_master_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_three_wire_burst_master_core_test
// Regression bench for the three-wire RTC burst master. It drives burst
// writes and burst reads as start transfers followed by their ticks, with
// random read-pin levels, stray starts and unused opcodes while busy, under
// several control byte settings, and leaves checking to the port checker.
// ----------------------------------------------------------------------------
module rtc_three_wire_burst_master_core_test;
    import rtcb_pkg::*;

    // Unused opcode, ignored by the block at any time
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [2:0] ADDR_FINAL_CTRL = 3'd0;

    // Ticks after the start: two commands, one enable pulse, nine bytes, close
    localparam int WR_TICKS = 2 * 16 + 1 + 9 * 16 + 1;
    // Ticks after the start: command, eight sampled bytes, close
    localparam int RD_TICKS = 16 + 8 * 16 + 1;

    localparam int RANDOM_ITEMS  = 300;
    localparam int RANDOM_PHASES = 2;
    localparam int HOLD_CYCLES   = 120;
    localparam int LIMIT_NS      = 1_000_000;

    // Read-pin level patterns
    localparam int IO_RANDOM = 0;
    localparam int IO_ONES   = 1;
    localparam int IO_ZEROS  = 2;
    localparam int IO_TOGGLE = 3;

    typedef struct packed {
        logic [2:0] pad;
        logic       io_sample;
        logic [6:0] year;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_time_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   chk_fails;
    int   chk_pending;

    int   burst_left;
    int   worked;
    int   strays;
    int   writes_done;
    int   reads_done;
    int   ctrl_settings;
    logic hold_ask;
    logic hold_done;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rtc_three_wire_burst_master_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rtc_three_wire_burst_master_core_checker #(
        .CTRL_ADDR (ADDR_FINAL_CTRL)
    ) u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_fails    (chk_fails),
        .o_pending  (chk_pending)
    );

    // Every bit of every field random, padding kept at zero
    function automatic t_time_word noise_word();
        logic [63:0] r;
        t_time_word  w;
        r = {$urandom, $urandom};
        w = r[39:0];
        w.pad = '0;
        return w;
    endfunction

    // A calendar setting, either in range or with the fields at full width
    function automatic t_time_word rand_time(input bit wild);
        t_time_word w;
        if (wild)
            return noise_word();
        w = '0;
        w.seconds   = 6'($urandom_range(0, 59));
        w.minutes   = 6'($urandom_range(0, 59));
        w.hour      = 5'($urandom_range(0, 23));
        w.date      = 5'($urandom_range(1, 31));
        w.month     = 4'($urandom_range(1, 12));
        w.weekday   = 3'($urandom_range(1, 7));
        w.year      = 7'($urandom_range(0, 99));
        w.io_sample = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Offers one transfer and waits until it is taken; bursts end in random gaps
    task automatic offer(input logic [1:0] op, input t_time_word w);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // A start or an unused opcode that the block has to ignore while busy
    task automatic stray_item();
        case ($urandom_range(0, 2))
            0:       offer(OP_START_WR, noise_word());
            1:       offer(OP_START_RD, noise_word());
            default: offer(OP_UNUSED, noise_word());
        endcase
        strays++;
    endtask

    task automatic ticks(input int n, input bit noisy, input int io_mode);
        t_time_word w;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 24) == 0)
                stray_item();
            w = noise_word();
            case (io_mode)
                IO_ONES:   w.io_sample = 1'b1;
                IO_ZEROS:  w.io_sample = 1'b0;
                IO_TOGGLE: w.io_sample = i[1];
                default:   ;
            endcase
            offer(OP_TICK, w);
        end
    endtask

    task automatic burst_write(input t_time_word w, input bit noisy);
        offer(OP_START_WR, w);
        ticks(WR_TICKS, noisy, IO_RANDOM);
        worked += WR_TICKS + 1;
        writes_done++;
    endtask

    task automatic burst_read(input int io_mode, input bit noisy);
        offer(OP_START_RD, noise_word());
        ticks(RD_TICKS, noisy, io_mode);
        worked += RD_TICKS + 1;
        reads_done++;
    endtask

    // Stops offering until every result due has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Setup and access cycle, then the bus goes idle before the next access
    task automatic reg_access(input logic wr, input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes the control byte and reads it straight back
    task automatic set_ctrl(input logic [7:0] v);
        reg_access(1'b1, ADDR_FINAL_CTRL, {24'h0, v});
        reg_access(1'b0, ADDR_FINAL_CTRL, '0);
        ctrl_settings++;
    endtask

    // Receiver: stretches of steady or random readiness, plus one long hold
    initial begin
        int span;
        int kind;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_ask && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            span = $urandom_range(8, 64);
            kind = $urandom_range(0, 3);
            repeat (span) begin
                case (kind)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 4) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        t_time_word w;
        int         quota;
        int         pick;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_TICK;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_ask      = 1'b0;
        burst_left    = 0;
        worked        = 0;
        strays        = 0;
        writes_done   = 0;
        reads_done    = 0;
        ctrl_settings = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Control byte straight out of reset
        reg_access(1'b0, ADDR_FINAL_CTRL, '0);

        // Nothing happens on a tick or an unused opcode while idle
        offer(OP_TICK, '0);
        w = '1;
        w.pad = '0;
        offer(OP_UNUSED, w);

        // Every field at full width; starts and the unused opcode while busy
        offer(OP_START_WR, w);
        ticks(3, 1'b0, IO_RANDOM);
        offer(OP_START_RD, '0);
        offer(OP_UNUSED, '0);
        offer(OP_START_WR, '0);
        ticks(WR_TICKS - 3, 1'b0, IO_RANDOM);
        writes_done++;

        // Calendar limits in range
        burst_write({3'b0, 1'b0, 7'd99, 3'd7, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b0);
        burst_write({3'b0, 1'b1, 7'd0, 3'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b0);

        // Read-back with the pin held high, held low and alternating
        burst_read(IO_ONES, 1'b0);
        burst_read(IO_ZEROS, 1'b0);
        burst_read(IO_TOGGLE, 1'b0);

        // Control byte extremes
        settle();
        set_ctrl(8'hFF);
        burst_write(rand_time(1'b0), 1'b0);
        settle();
        set_ctrl(8'h00);
        burst_write(rand_time(1'b1), 1'b0);
        burst_read(IO_RANDOM, 1'b0);

        // Random part, in phases with a fresh control byte each
        worked = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            set_ctrl(8'($urandom_range(0, 255)));
            if (ph == 0)
                hold_ask = 1'b1;
            quota = worked + RANDOM_ITEMS / RANDOM_PHASES;
            while (worked < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    burst_write(rand_time($urandom_range(0, 3) == 0), 1'b1);
                end else if (pick < 88) begin
                    burst_read(IO_RANDOM, 1'b1);
                end else begin
                    // Idle ticks and unused opcodes between transactions
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 1) == 0)
                            offer(OP_TICK, noise_word());
                        else
                            offer(OP_UNUSED, noise_word());
                    end
                end
                if ($urandom_range(0, 7) == 0)
                    settle();
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d burst writes and %0d burst reads under %0d control byte values,",
                 writes_done, reads_done, ctrl_settings);
        $display("with %0d ignored starts or unused opcodes offered while busy.", strays);
        if (chk_fails == 0)
            $display("rtc_three_wire_burst_master_core regression: pass");
        else
            $display("rtc_three_wire_burst_master_core regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("Run stopped by the watchdog with results still due.");
        $display("rtc_three_wire_burst_master_core regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/rtcb_pkg.sv
rtl/rtc_three_wire_burst_master_core.sv
rtl/rtcb_checker.sv
tb/rtc_three_wire_burst_master_core_checker.sv
tb/rtc_three_wire_burst_master_core_test.sv
